### hw/rtl/etfr_pkg.sv
// shared types, constants and the crc-8 step for the telemetry frame receiver
`timescale 1ns / 1ps

package etfr_pkg;

  localparam int FrameLenDefault = 10;
  localparam int JobDepthDefault = 2;
  // bytes 0..8 carry the decoded fields
  localparam int DecodeBytes     = 9;

  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] RpmScale   = 8'd200;
  localparam int         PolesW     = 7;
  localparam logic [6:0] PolesReset = 7'd14;
  localparam logic [6:0] PolesMin   = 7'd2;
  localparam int         RpmProdW   = 24;
  localparam int         RpmW       = 23;

  typedef struct packed {
    logic                crc_ok;
    logic [7:0]          temperature;
    logic [15:0]         centivolts;
    logic [15:0]         centiamps;
    logic [15:0]         mah;
    logic [15:0]         rpm_raw;
    logic [PolesW-1:0]   poles;
  } job_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CrcPoly) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

### hw/rtl/etfr_front.sv
// front end: byte acceptance, frame buffer, running crc and job build
`timescale 1ns / 1ps

module etfr_front #(
  parameter int FRAME_LEN = etfr_pkg::FrameLenDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [7:0]                  rx_byte_i,
  output logic                        full_o,
  input  logic [etfr_pkg::PolesW-1:0] poles_i,
  input  logic                        job_full_i,
  output logic                        job_push_o,
  output etfr_pkg::job_t              job_o
);

  localparam int            IdxW    = $clog2(FRAME_LEN);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FRAME_LEN - 1);

  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      frame_q [etfr_pkg::DecodeBytes];
  logic            last_byte;
  logic            accept;
  logic [etfr_pkg::PolesW-1:0] poles_eff;

  assign last_byte = (idx_q == LastIdx);
  // only the closing byte needs room in the job queue
  assign full_o    = last_byte && job_full_i;
  assign accept    = push_i && !full_o;

  always_comb begin
    idx_d = idx_q;
    crc_d = crc_q;
    if (accept) begin
      if (last_byte) begin
        idx_d = '0;
        crc_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
        crc_d = etfr_pkg::crc8_step(crc_q, rx_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      crc_q <= '0;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < etfr_pkg::DecodeBytes; k++) begin
      if (accept && (idx_q == IdxW'(k))) begin
        frame_q[k] <= rx_byte_i;
      end
    end
  end

  assign poles_eff = (poles_i < etfr_pkg::PolesMin) ? etfr_pkg::PolesMin : poles_i;

  assign job_push_o         = accept && last_byte;
  assign job_o.crc_ok       = (crc_q == rx_byte_i);
  assign job_o.temperature  = frame_q[0];
  assign job_o.centivolts   = {frame_q[1], frame_q[2]};
  assign job_o.centiamps    = {frame_q[3], frame_q[4]};
  assign job_o.mah          = {frame_q[5], frame_q[6]};
  assign job_o.rpm_raw      = {frame_q[7], frame_q[8]};
  assign job_o.poles        = poles_eff;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx)
    else $error("byte index ran past the frame");
`endif

endmodule

### hw/rtl/etfr_fifo.sv
// short job queue between front and back end
`timescale 1ns / 1ps

module etfr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = etfr_pkg::JobDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("job queue count out of range");
`endif

endmodule

### hw/rtl/etfr_back.sv
// back end: rpm scaling, bit-serial division and result register
`timescale 1ns / 1ps

module etfr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  input  etfr_pkg::job_t            job_i,
  output logic                      job_pop_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic                      crc_ok_o,
  output logic [7:0]                temperature_o,
  output logic [15:0]               motor_centivolts_o,
  output logic [15:0]               current_centiamps_o,
  output logic [15:0]               consumption_mah_o,
  output logic [etfr_pkg::RpmW-1:0] rpm_o
);

  localparam int ProdW = etfr_pkg::RpmProdW;
  localparam int PW    = etfr_pkg::PolesW;
  localparam int StepW = $clog2(ProdW);
  localparam logic [StepW-1:0] LastStep = StepW'(ProdW - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WRITE
  } state_e;

  state_e               state_q, state_d;
  etfr_pkg::job_t       job_q, job_d;
  logic [ProdW-1:0]     quo_q, quo_d;
  logic [PW-1:0]        rem_q, rem_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 crc_ok_q, crc_ok_d;
  logic [7:0]           temp_q, temp_d;
  logic [15:0]          volts_q, volts_d;
  logic [15:0]          amps_q, amps_d;
  logic [15:0]          mah_q, mah_d;
  logic [etfr_pkg::RpmW-1:0] rpm_q, rpm_d;

  logic [PW:0]          rem_sh;
  logic [PW:0]          rem_sub;
  logic                 rem_ge;
  logic                 slot_free;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[ProdW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, job_q.poles});
  assign rem_sub = rem_sh - {1'b0, job_q.poles};

  assign slot_free = !out_valid_q || pop_i;
  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !pop_i;
    crc_ok_d    = crc_ok_q;
    temp_d      = temp_q;
    volts_d     = volts_q;
    amps_d      = amps_q;
    mah_d       = mah_q;
    rpm_d       = rpm_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_d   = job_i;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        quo_d   = {8'b0, job_q.rpm_raw} * {16'b0, etfr_pkg::RpmScale};
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d  = rem_ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
        quo_d  = {quo_q[ProdW-2:0], rem_ge};
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          crc_ok_d    = job_q.crc_ok;
          if (job_q.crc_ok) begin
            temp_d  = job_q.temperature;
            volts_d = job_q.centivolts;
            amps_d  = job_q.centiamps;
            mah_d   = job_q.mah;
            rpm_d   = quo_q[etfr_pkg::RpmW-1:0];
          end else begin
            temp_d  = '0;
            volts_d = '0;
            amps_d  = '0;
            mah_d   = '0;
            rpm_d   = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      job_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      crc_ok_q    <= 1'b0;
      temp_q      <= '0;
      volts_q     <= '0;
      amps_q      <= '0;
      mah_q       <= '0;
      rpm_q       <= '0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      crc_ok_q    <= crc_ok_d;
      temp_q      <= temp_d;
      volts_q     <= volts_d;
      amps_q      <= amps_d;
      mah_q       <= mah_d;
      rpm_q       <= rpm_d;
    end
  end

  assign empty_o             = !out_valid_q;
  assign crc_ok_o            = crc_ok_q;
  assign temperature_o       = temp_q;
  assign motor_centivolts_o  = volts_q;
  assign current_centiamps_o = amps_q;
  assign consumption_mah_o   = mah_q;
  assign rpm_o               = rpm_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) && out_valid_q && !pop_i |=> (state_q == S_WRITE) && out_valid_q)
    else $error("result register overwritten while still waiting");
  a_bad_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !crc_ok_q |-> (rpm_q == '0) && (temp_q == '0) && (volts_q == '0))
    else $error("failed frame carries nonzero fields");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> (state_q == S_MUL))
    else $error("job taken without starting the scaling");
`endif

endmodule

### hw/rtl/esc_telemetry_frame_receiver_core.sv
// top level of the esc telemetry frame receiver with crc-8 check
`timescale 1ns / 1ps

// usage
// - byte input is queue-like: a byte transaction completes when push is high and
//   full is low; full only rises on the closing byte of a frame when the job
//   queue has no room, so bytes inside a frame are always taken at once
// - results are queue-like too: the frame result sits on the output ports while
//   empty is low and is consumed on pop; one result per FRAME_LEN bytes
// - the pole count is written through cfg_valid_i / cfg_ready_o / cfg_data_i;
//   cfg_ready_o is always high, values below two count as two
// - path from closing byte to result: queue pop, rpm scaling multiply,
//   bit-serial division, result load
// - throughput: one byte per cycle at the input while full is low; the back
//   end works on one frame at a time, paced by the 24-step divider, and takes
//   the next job only after the result load
// - a stalled receiver holds the result register; the back end finishes the
//   next frame and waits, and the job queue takes further frames until full
// - reset clears byte index, crc, queue, back end and the result register, and
//   sets the pole count to 14; no clearing pass is needed

module esc_telemetry_frame_receiver_core #(
  parameter int FRAME_LEN = etfr_pkg::FrameLenDefault,
  parameter int JOB_DEPTH = etfr_pkg::JobDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  rx_byte_i,
  // result output
  output logic                        empty,
  input  logic                        pop,
  output logic                        crc_ok_o,
  output logic [7:0]                  temperature_o,
  output logic [15:0]                 motor_centivolts_o,
  output logic [15:0]                 current_centiamps_o,
  output logic [15:0]                 consumption_mah_o,
  output logic [etfr_pkg::RpmW-1:0]   rpm_o,
  // configuration
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [etfr_pkg::PolesW-1:0] cfg_data_i
);

  localparam int JobW = $bits(etfr_pkg::job_t);

  logic [etfr_pkg::PolesW-1:0] poles_q;
  etfr_pkg::job_t              job_wr;
  etfr_pkg::job_t              job_rd;
  logic [JobW-1:0]             job_rd_bits;
  logic                        job_push;
  logic                        job_full;
  logic                        job_pop;
  logic                        job_empty;

  // pole count register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poles_q <= etfr_pkg::PolesReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      poles_q <= cfg_data_i;
    end
  end

  // byte acceptance, crc and frame buffer
  etfr_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .poles_i    (poles_q),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_wr)
  );

  // decoupling queue of finished frames
  etfr_fifo #(
    .WIDTH (JobW),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (job_wr),
    .full_o  (job_full),
    .rd_i    (job_pop),
    .rdata_o (job_rd_bits),
    .empty_o (job_empty)
  );

  assign job_rd = etfr_pkg::job_t'(job_rd_bits);

  // rpm scaling, division and result register
  etfr_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .job_valid_i         (!job_empty),
    .job_i               (job_rd),
    .job_pop_o           (job_pop),
    .pop_i               (pop),
    .empty_o             (empty),
    .crc_ok_o            (crc_ok_o),
    .temperature_o       (temperature_o),
    .motor_centivolts_o  (motor_centivolts_o),
    .current_centiamps_o (current_centiamps_o),
    .consumption_mah_o   (consumption_mah_o),
    .rpm_o               (rpm_o)
  );

endmodule

### dv/esc_telemetry_frame_receiver_core_tb.sv
// self-checking testbench for the esc telemetry frame receiver core
`timescale 1ns / 1ps

module esc_telemetry_frame_receiver_core_tb;

  localparam int         FrameLen       = etfr_pkg::FrameLenDefault;
  localparam int         PolesW         = etfr_pkg::PolesW;
  localparam int         RpmW           = etfr_pkg::RpmW;
  localparam logic [7:0] CrcPoly        = etfr_pkg::CrcPoly;
  localparam logic [7:0] RpmScale       = etfr_pkg::RpmScale;
  localparam logic [6:0] PolesReset     = etfr_pkg::PolesReset;
  localparam logic [6:0] PolesMin       = etfr_pkg::PolesMin;
  localparam int         FramesPerPhase = 7;
  localparam int         PolePhases     = 8;
  localparam int         FixedPhases    = 6;
  localparam int         SettleCycles   = 40;
  localparam int         StallLimit     = 2000;

  typedef struct packed {
    logic             crc_ok;
    logic [7:0]       temperature;
    logic [15:0]      centivolts;
    logic [15:0]      centiamps;
    logic [15:0]      mah;
    logic [RpmW-1:0]  rpm;
  } telemetry_t;

  typedef enum int {FrameGood, FrameBadCrc, FrameNoise} frame_kind_e;
  typedef enum int {FillRandom, FillOnes, FillZeros, FillMaxRpm} fill_e;

  // decodes accepted bytes into the frame results that the core must produce
  class frame_scoreboard;
    logic [7:0]        frame_buf [FrameLen];
    int unsigned       byte_pos;
    logic [7:0]        crc_acc;
    logic [PolesW-1:0] poles;
    telemetry_t        decoded_q [$];
    int unsigned       mismatches;
    int unsigned       good_frames;
    int unsigned       bad_frames;

    function new();
      byte_pos    = 0;
      crc_acc     = 8'h00;
      poles       = PolesReset;
      mismatches  = 0;
      good_frames = 0;
      bad_frames  = 0;
    endfunction

    // crc-8, poly 0x07, msb first, no reflection
    static function logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) r = (r << 1) ^ (r[7] ? CrcPoly : 8'h00);
      return r;
    endfunction

    function void set_poles(logic [PolesW-1:0] value);
      poles = value;
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function void take_byte(logic [7:0] b);
      telemetry_t  t;
      int unsigned raw;
      int unsigned divisor;
      frame_buf[byte_pos] = b;
      if (byte_pos < FrameLen - 1) crc_acc = crc8_next(crc_acc, b);
      byte_pos++;
      if (byte_pos < FrameLen) return;
      t = '0;
      // a crc mismatch leaves every decoded field at zero
      if (crc_acc == frame_buf[FrameLen-1]) begin
        divisor       = (poles < PolesMin) ? PolesMin : poles;
        raw           = {frame_buf[7], frame_buf[8]};
        t.crc_ok      = 1'b1;
        t.temperature = frame_buf[0];
        t.centivolts  = {frame_buf[1], frame_buf[2]};
        t.centiamps   = {frame_buf[3], frame_buf[4]};
        t.mah         = {frame_buf[5], frame_buf[6]};
        t.rpm         = RpmW'((raw * RpmScale) / divisor);
        good_frames++;
      end else begin
        bad_frames++;
      end
      decoded_q.push_back(t);
      byte_pos = 0;
      crc_acc  = 8'h00;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_frame(telemetry_t got);
      telemetry_t want;
      if (decoded_q.size() == 0) begin
        $display("%0t: frame result with none pending, expected nothing, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = decoded_q.pop_front();
      compare_field("crc_ok", want.crc_ok, got.crc_ok);
      compare_field("temperature", want.temperature, got.temperature);
      compare_field("motor_centivolts", want.centivolts, got.centivolts);
      compare_field("current_centiamps", want.centiamps, got.centiamps);
      compare_field("consumption_mah", want.mah, got.mah);
      compare_field("rpm", want.rpm, got.rpm);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                push;
  logic                full;
  logic [7:0]          rx_byte_i;
  logic                empty;
  logic                pop;
  logic                crc_ok_o;
  logic [7:0]          temperature_o;
  logic [15:0]         motor_centivolts_o;
  logic [15:0]         current_centiamps_o;
  logic [15:0]         consumption_mah_o;
  logic [RpmW-1:0]     rpm_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [PolesW-1:0]   cfg_data_i;

  frame_scoreboard sb;
  int unsigned     feed_idle_pct  = 25;
  int unsigned     drain_idle_pct = 25;
  int unsigned     stall_cycles   = 0;

  esc_telemetry_frame_receiver_core i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .rx_byte_i           (rx_byte_i),
    .empty               (empty),
    .pop                 (pop),
    .crc_ok_o            (crc_ok_o),
    .temperature_o       (temperature_o),
    .motor_centivolts_o  (motor_centivolts_o),
    .current_centiamps_o (current_centiamps_o),
    .consumption_mah_o   (consumption_mah_o),
    .rpm_o               (rpm_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ends the run when no transaction of any kind completes for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side: random pop, outputs sampled as they were before the edge
  initial begin
    telemetry_t got;
    pop = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      pop <= ($urandom_range(99) >= drain_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) begin
        got.crc_ok      = crc_ok_o;
        got.temperature = temperature_o;
        got.centivolts  = motor_centivolts_o;
        got.centiamps   = current_centiamps_o;
        got.mah         = consumption_mah_o;
        got.rpm         = rpm_o;
        sb.check_frame(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < feed_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.take_byte(b);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // nine payload bytes, then a closing byte chosen by the frame kind
  task automatic send_frame(input frame_kind_e kind, input fill_e fill);
    logic [7:0] crc;
    logic [7:0] b;
    crc = 8'h00;
    for (int i = 0; i < FrameLen - 1; i++) begin
      case (fill)
        FillOnes:  b = 8'hff;
        FillZeros: b = 8'h00;
        default:   b = pick_byte();
      endcase
      // raw rpm bytes at full scale
      if (fill == FillMaxRpm && (i == 7 || i == 8)) b = 8'hff;
      crc = frame_scoreboard::crc8_next(crc, b);
      send_byte(b);
    end
    case (kind)
      FrameGood:   send_byte(crc);
      FrameBadCrc: send_byte(crc ^ 8'($urandom_range(1, 255)));
      default:     send_byte(pick_byte());
    endcase
  endtask

  task automatic drain_and_settle();
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_poles(input logic [PolesW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_poles(value);
  endtask

  initial begin
    logic [PolesW-1:0] fixed_poles [FixedPhases];
    logic [PolesW-1:0] poles;
    int unsigned       roll;
    frame_kind_e       kind;
    // pole settings below two clamp to two; 65 and up are used unchanged
    fixed_poles = '{7'd1, 7'd0, 7'd2, 7'd64, 7'd127, 7'd65};
    sb          = new();
    push        = 1'b0;
    rx_byte_i   = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pole count: full-scale fields with a good crc, then zeros with a bad one
    send_frame(FrameGood, FillOnes);
    send_frame(FrameBadCrc, FillZeros);

    for (int p = 0; p < PolePhases; p++) begin
      drain_and_settle();
      poles = (p < FixedPhases) ? fixed_poles[p] : PolesW'($urandom_range(3, 126));
      write_poles(poles);
      // one phase runs back to back on both sides so the job queue fills up
      feed_idle_pct  = (p == 2) ? 0 : 25;
      drain_idle_pct = (p == 2) ? 0 : 25;
      for (int f = 0; f < FramesPerPhase; f++) begin
        roll = $urandom_range(99);
        kind = (roll < 75) ? FrameGood : (roll < 90) ? FrameBadCrc : FrameNoise;
        send_frame(kind, (f == 0) ? FillMaxRpm : FillRandom);
      end
    end
    drain_and_settle();

    $display("covered %0d frames (%0d good crc, %0d bad crc) across %0d pole settings",
             sb.good_frames + sb.bad_frames, sb.good_frames, sb.bad_frames,
             PolePhases + 1);
    $display("pole counts 0, 1, 2, 14, 64, 65 and 127 seen, with queue back pressure");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/etfr_pkg.sv
hw/rtl/etfr_front.sv
hw/rtl/etfr_fifo.sv
hw/rtl/etfr_back.sv
hw/rtl/esc_telemetry_frame_receiver_core.sv
dv/esc_telemetry_frame_receiver_core_tb.sv
